// File: hdl/mmcd_pkg.sv
// Shared types and constants for the min/max column decimator.
package mmcd_pkg;

  localparam int SAMPLE_BITS = 8;
  localparam int COUNT_W     = 16;
  localparam int COL_W       = 10;
  localparam int PPC_W       = 32;
  localparam int SCALE_W     = 24;
  localparam int ROW_W       = 10;
  localparam int X_W         = 11;
  // Accumulator holds (columns+1)*P plus the rounding half; 43 bits never wrap.
  localparam int ACC_W       = 43;
  localparam int FRAC_W      = 16;
  localparam int PROD_W      = SAMPLE_BITS + SCALE_W;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_SAMPLE_COUNT = 3'd0;
  localparam logic [2:0] REG_COLUMN_COUNT = 3'd1;
  localparam logic [2:0] REG_POINTS_PER   = 3'd2;
  localparam logic [2:0] REG_ROW_SCALE    = 3'd3;
  localparam logic [2:0] REG_BASE_ROW     = 3'd4;
  localparam logic [2:0] REG_X_ORIGIN     = 3'd5;

  localparam logic [COUNT_W-1:0] RST_SAMPLE_COUNT = 16'd512;
  localparam logic [COL_W-1:0]   RST_COLUMN_COUNT = 10'd278;
  localparam logic [PPC_W-1:0]   RST_POINTS_PER   = 32'd119837;
  localparam logic [SCALE_W-1:0] RST_ROW_SCALE    = 24'd65536;
  localparam logic [ROW_W-1:0]   RST_BASE_ROW     = 10'd255;
  localparam logic [COL_W-1:0]   RST_X_ORIGIN     = 10'd0;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
  localparam logic [COUNT_W-1:0]     INDEX_MAX  = '1;
  localparam logic [ACC_W-1:0]       ROUND_HALF = ACC_W'(1) << (FRAC_W - 1);

  typedef struct packed {
    logic [COUNT_W-1:0] sample_count;
    logic [COL_W-1:0]   column_count;
    logic [PPC_W-1:0]   points_per_column;
    logic [SCALE_W-1:0] row_scale;
    logic [ROW_W-1:0]   base_row;
    logic [COL_W-1:0]   x_origin;
  } cfg_t;

  // One closed column on its way to the row arithmetic.
  typedef struct packed {
    logic [X_W-1:0]         screen_x;
    logic [SAMPLE_BITS-1:0] col_min;
    logic [SAMPLE_BITS-1:0] col_max;
    logic                   last_column;
  } column_t;

endpackage

// File: hdl/mmcd_regs.sv
// Configuration register file behind the APB-style port.
module mmcd_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mmcd_pkg::ADDR_W-1:0] paddr,
  input  logic [mmcd_pkg::DATA_W-1:0] pwdata,
  output logic [mmcd_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output mmcd_pkg::cfg_t              cfg
);
  import mmcd_pkg::*;

  cfg_t       cfg_r;
  logic [2:0] reg_sel;
  logic       wr_en;

  assign reg_sel = paddr[ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  // Register writes land on the access cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_count      <= RST_SAMPLE_COUNT;
      cfg_r.column_count      <= RST_COLUMN_COUNT;
      cfg_r.points_per_column <= RST_POINTS_PER;
      cfg_r.row_scale         <= RST_ROW_SCALE;
      cfg_r.base_row          <= RST_BASE_ROW;
      cfg_r.x_origin          <= RST_X_ORIGIN;
    end else if (wr_en) begin
      case (reg_sel)
        REG_SAMPLE_COUNT: cfg_r.sample_count      <= pwdata[COUNT_W-1:0];
        REG_COLUMN_COUNT: cfg_r.column_count      <= pwdata[COL_W-1:0];
        REG_POINTS_PER:   cfg_r.points_per_column <= pwdata[PPC_W-1:0];
        REG_ROW_SCALE:    cfg_r.row_scale         <= pwdata[SCALE_W-1:0];
        REG_BASE_ROW:     cfg_r.base_row          <= pwdata[ROW_W-1:0];
        REG_X_ORIGIN:     cfg_r.x_origin          <= pwdata[COL_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux, zero-extended to the bus width.
  always_comb begin
    case (reg_sel)
      REG_SAMPLE_COUNT: prdata = DATA_W'(cfg_r.sample_count);
      REG_COLUMN_COUNT: prdata = DATA_W'(cfg_r.column_count);
      REG_POINTS_PER:   prdata = DATA_W'(cfg_r.points_per_column);
      REG_ROW_SCALE:    prdata = DATA_W'(cfg_r.row_scale);
      REG_BASE_ROW:     prdata = DATA_W'(cfg_r.base_row);
      REG_X_ORIGIN:     prdata = DATA_W'(cfg_r.x_origin);
      default:          prdata = '0;
    endcase
  end

endmodule

// File: hdl/mmcd_track.sv
// Column tracker: sample counting, column boundaries and running min/max.
module mmcd_track (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mmcd_pkg::cfg_t                   cfg,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [mmcd_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                             in_first,
  output logic                             col_valid,
  input  logic                             col_ready,
  output mmcd_pkg::column_t                col_word
);
  import mmcd_pkg::*;

  logic [COUNT_W-1:0]     sample_index_r, sample_index_nxt;
  logic [COL_W-1:0]       column_index_r, column_index_nxt;
  logic [ACC_W-1:0]       acc_r, acc_nxt;
  logic [SAMPLE_BITS-1:0] min_r, min_nxt;
  logic [SAMPLE_BITS-1:0] max_r, max_nxt;
  logic                   col_valid_r;
  column_t                col_word_r;

  logic [COUNT_W-1:0]     idx;
  logic [COL_W-1:0]       col;
  logic [ACC_W-1:0]       acc;
  logic [SAMPLE_BITS-1:0] cur_min, cur_max, upd_min, upd_max;
  logic                   skip, emit, accept, stage_ready;
  column_t                word_nxt;

  // The output slot frees when empty or when its word moves on.
  assign stage_ready = !col_valid_r || col_ready;
  assign in_stall    = !stage_ready;
  assign accept      = in_valid && stage_ready;
  assign col_valid   = col_valid_r;
  assign col_word    = col_word_r;

  // Per-sample update; a first-marked word starts from the restart values.
  always_comb begin
    if (in_first) begin
      idx     = '0;
      col     = '0;
      acc     = ACC_W'(cfg.points_per_column) + ROUND_HALF;
      cur_min = SAMPLE_MAX;
      cur_max = '0;
    end else begin
      idx     = sample_index_r;
      col     = column_index_r;
      acc     = acc_r;
      cur_min = min_r;
      cur_max = max_r;
    end

    sample_index_nxt = (idx < INDEX_MAX) ? idx + COUNT_W'(1) : idx;
    skip = (idx >= cfg.sample_count) || (col >= cfg.column_count);

    upd_min = (in_sample < cur_min) ? in_sample : cur_min;
    upd_max = (in_sample > cur_max) ? in_sample : cur_max;

    // The accumulator already carries the half, so its integer part is the end.
    emit = !skip &&
           ((ACC_W - FRAC_W)'(idx) + (ACC_W - FRAC_W)'(1) >= acc[ACC_W-1:FRAC_W]);

    word_nxt.screen_x    = X_W'(cfg.x_origin) + X_W'(col);
    word_nxt.col_min     = upd_min;
    word_nxt.col_max     = upd_max;
    word_nxt.last_column = (X_W'(col) + X_W'(1)) == X_W'(cfg.column_count);

    column_index_nxt = col;
    acc_nxt          = acc;
    min_nxt          = cur_min;
    max_nxt          = cur_max;
    if (emit) begin
      column_index_nxt = col + COL_W'(1);
      acc_nxt          = acc + ACC_W'(cfg.points_per_column);
      min_nxt          = SAMPLE_MAX;
      max_nxt          = '0;
    end else if (!skip) begin
      min_nxt = upd_min;
      max_nxt = upd_max;
    end
  end

  // Tracker state and the closed-column register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_index_r <= '0;
      column_index_r <= '0;
      acc_r          <= ACC_W'(RST_POINTS_PER) + ROUND_HALF;
      min_r          <= SAMPLE_MAX;
      max_r          <= '0;
      col_valid_r    <= 1'b0;
    end else begin
      if (accept) begin
        sample_index_r <= sample_index_nxt;
        column_index_r <= column_index_nxt;
        acc_r          <= acc_nxt;
        min_r          <= min_nxt;
        max_r          <= max_nxt;
      end
      if (stage_ready) begin
        col_valid_r <= accept && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready) begin
      col_word_r <= word_nxt;
    end
  end

endmodule

// File: hdl/mmcd_rows.sv
// Row arithmetic: scale both extremes, round, and subtract from the base row.
module mmcd_rows (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mmcd_pkg::cfg_t             cfg,
  input  logic                       col_valid,
  output logic                       col_ready,
  input  mmcd_pkg::column_t          col_word,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [mmcd_pkg::X_W-1:0]   out_screen_x,
  output logic [mmcd_pkg::ROW_W-1:0] out_row_of_min,
  output logic [mmcd_pkg::ROW_W-1:0] out_row_of_max,
  output logic                       out_last_column
);
  import mmcd_pkg::*;

  localparam int OFF_W = PROD_W + 1 - FRAC_W;

  logic              prod_valid_r;
  logic [PROD_W-1:0] prod_min_r, prod_max_r;
  logic [X_W-1:0]    prod_x_r;
  logic              prod_last_r;
  logic              out_valid_r;
  logic [X_W-1:0]    out_x_r;
  logic [ROW_W-1:0]  row_min_r, row_max_r;
  logic              out_last_r;
  logic              out_ready, prod_ready;
  logic [ROW_W-1:0]  row_min_nxt, row_max_nxt;

  // Rounded offset subtracted from the base row, clipped at row zero.
  function automatic logic [ROW_W-1:0] row_for(input logic [PROD_W-1:0] prod,
                                               input logic [ROW_W-1:0]  base);
    logic [PROD_W:0]  rounded;
    logic [OFF_W-1:0] off;
    rounded = {1'b0, prod} + (PROD_W + 1)'(1 << (FRAC_W - 1));
    off     = rounded[PROD_W:FRAC_W];
    if (off >= OFF_W'(base)) begin
      return '0;
    end
    return base - off[ROW_W-1:0];
  endfunction

  assign out_ready  = !out_valid_r || !out_stall;
  assign prod_ready = !prod_valid_r || out_ready;
  assign col_ready  = prod_ready;

  assign row_min_nxt = row_for(prod_min_r, cfg.base_row);
  assign row_max_nxt = row_for(prod_max_r, cfg.base_row);

  // Valid flags of the product and output stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (prod_ready) begin
        prod_valid_r <= col_valid;
      end
      if (out_ready) begin
        out_valid_r <= prod_valid_r;
      end
    end
  end

  // Product stage: one 8x24 multiply for each extreme.
  always_ff @(posedge clk) begin
    if (prod_ready) begin
      prod_min_r  <= PROD_W'(col_word.col_min) * PROD_W'(cfg.row_scale);
      prod_max_r  <= PROD_W'(col_word.col_max) * PROD_W'(cfg.row_scale);
      prod_x_r    <= col_word.screen_x;
      prod_last_r <= col_word.last_column;
    end
  end

  // Output stage holds the word while the consumer stalls.
  always_ff @(posedge clk) begin
    if (out_ready) begin
      out_x_r    <= prod_x_r;
      row_min_r  <= row_min_nxt;
      row_max_r  <= row_max_nxt;
      out_last_r <= prod_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_screen_x    = out_x_r;
  assign out_row_of_min  = row_min_r;
  assign out_row_of_max  = row_max_r;
  assign out_last_column = out_last_r;

endmodule

// File: hdl/minmax_column_decimator.sv
// Min/max column decimator: splits a sample stream into display columns.
// Takes one sample word per cycle when the output side keeps up.
// A column's word reaches out after the sample that closes it is accepted, passing the
// tracker register, multiply register and row register in order; each stage holds under stall.
// Synchronous active-low reset restores the register defaults, clears the pipeline
// and restarts the capture state (index and column zero, empty min/max).
module minmax_column_decimator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [mmcd_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                             in_first,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mmcd_pkg::X_W-1:0]         out_screen_x,
  output logic [mmcd_pkg::ROW_W-1:0]       out_row_of_min,
  output logic [mmcd_pkg::ROW_W-1:0]       out_row_of_max,
  output logic                             out_last_column,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mmcd_pkg::ADDR_W-1:0]      paddr,
  input  logic [mmcd_pkg::DATA_W-1:0]      pwdata,
  output logic [mmcd_pkg::DATA_W-1:0]      prdata,
  output logic                             pready
);
  import mmcd_pkg::*;

  cfg_t    cfg;
  logic    col_valid;
  logic    col_ready;
  column_t col_word;

  mmcd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mmcd_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .in_first  (in_first),
    .col_valid (col_valid),
    .col_ready (col_ready),
    .col_word  (col_word)
  );

  mmcd_rows u_rows (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .col_valid       (col_valid),
    .col_ready       (col_ready),
    .col_word        (col_word),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_screen_x    (out_screen_x),
    .out_row_of_min  (out_row_of_min),
    .out_row_of_max  (out_row_of_max),
    .out_last_column (out_last_column)
  );

endmodule
